[rtl/longest_prefix_match_table_core_defines.svh]
// assertion macros shared by the checker
`ifndef LONGEST_PREFIX_MATCH_TABLE_CORE_DEFINES_SVH
`define LONGEST_PREFIX_MATCH_TABLE_CORE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define LPM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define LPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lpm_pkg.sv]
`default_nettype none
package lpm_pkg;
    localparam int unsigned TableEntriesDefault = 64;
    localparam int unsigned V4Width = 32;
    localparam int unsigned V6Width = 128;
    localparam logic [7:0] V4WidthLen = 8'd32;
    localparam logic [7:0] V6WidthLen = 8'd128;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_MISS   = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADLEN = 2'd3
    } t_status;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request
        logic clear;     // reset scan accumulators
        logic step;      // examine entry at scan index
        logic write;     // write entry at chosen slot
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic is_lookup;
        logic bad_len;
        logic last;      // scan index at final entry
        logic matched;   // lookup hit, or insert found an identical entry
        logic has_free;
    } t_sts;

    // mask of top len bits of 128
    function automatic logic [127:0] prefix_mask(input logic [7:0] len);
        logic [127:0] m;
        m = '0;
        for (int b = 0; b < 128; b++) begin
            m[127 - b] = (b < int'(len));
        end
        return m;
    endfunction
endpackage
`default_nettype wire

[rtl/lpm_ctrl.sv]
`default_nettype none
module lpm_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_start,
    input  wire lpm_pkg::t_sts i_sts,
    output lpm_pkg::t_ctl   o_ctl,
    output logic            o_busy,
    output logic            o_done,
    output logic [1:0]      o_status_sel
);
    typedef enum logic [1:0] {S_IDLE, S_CHECK, S_SCAN, S_FIN} t_state;
    t_state r_state;

    // command decode
    always_comb begin
        o_ctl = '0;
        o_ctl.load  = (r_state == S_IDLE) && i_start;
        o_ctl.clear = o_ctl.load;
        o_ctl.step  = (r_state == S_SCAN);
        o_ctl.write = (r_state == S_FIN) && !i_sts.is_lookup && !i_sts.matched
                      && i_sts.has_free;
    end

    // state and registered result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            o_done       <= 1'b0;
            o_status_sel <= lpm_pkg::ST_OK;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: if (i_start) r_state <= S_CHECK;
                S_CHECK: begin
                    if (i_sts.bad_len && !i_sts.is_lookup) begin
                        o_done       <= 1'b1;
                        o_status_sel <= lpm_pkg::ST_BADLEN;
                        r_state      <= S_IDLE;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: if (i_sts.last) r_state <= S_FIN;
                S_FIN: begin
                    o_done <= 1'b1;
                    if (i_sts.is_lookup) o_status_sel <= i_sts.matched ?
                        lpm_pkg::ST_OK : lpm_pkg::ST_MISS;
                    else if (i_sts.matched || i_sts.has_free)
                        o_status_sel <= lpm_pkg::ST_OK;
                    else o_status_sel <= lpm_pkg::ST_FULL;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

[rtl/lpm_datapath.sv]
`default_nettype none
module lpm_datapath #(
    parameter int unsigned TABLE_ENTRIES = lpm_pkg::TableEntriesDefault
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire lpm_pkg::t_ctl i_ctl,
    input  wire             i_command,
    input  wire             i_is_v6,
    input  wire [63:0]      i_address_high,
    input  wire [63:0]      i_address_low,
    input  wire [7:0]       i_prefix_len,
    input  wire [15:0]      i_route_in,
    output lpm_pkg::t_sts   o_sts,
    output logic [15:0]     o_match_route
);
    localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // entry store, one registered row read per cycle
    logic [152:0] r_mem [TABLE_ENTRIES];   // family, high, low, length, route
    logic [152:0] r_row;
    logic [TABLE_ENTRIES-1:0] r_valid;

    logic         r_cmd, r_fam;
    logic [127:0] r_addr;
    logic [7:0]   r_len;
    logic [15:0]  r_route;
    logic [IdxW-1:0] r_idx, r_free_idx;
    logic         r_has_free, r_matched;
    logic [7:0]   r_best_len;

    logic [IdxW-1:0] w_next_idx;
    logic [127:0] w_ins_mask, w_ins_prefix, w_ent_mask;
    logic         w_row_valid, w_fam_eq, w_cover, w_exact;

    assign w_next_idx   = (r_idx == IdxW'(TABLE_ENTRIES - 1)) ? '0 : r_idx + 1'b1;
    assign w_ins_mask   = lpm_pkg::prefix_mask(r_len);
    assign w_ins_prefix = r_addr & w_ins_mask;
    assign w_row_valid  = r_valid[r_idx];
    assign w_ent_mask   = lpm_pkg::prefix_mask(r_row[23:16]);
    assign w_fam_eq     = (r_row[152] == r_fam);
    assign w_cover      = ((r_addr & w_ent_mask) == r_row[151:24])
                          && (r_row[23:16] <= lpm_pkg::V6WidthLen);
    assign w_exact      = (r_row[23:16] == r_len) && (r_row[151:24] == w_ins_prefix);

    // request capture and scan accumulators
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_command;
            r_fam   <= i_is_v6;
            r_addr  <= {i_address_high, i_address_low};
            r_len   <= i_prefix_len;
            r_route <= i_route_in;
        end
        if (i_ctl.clear) begin
            r_idx      <= '0;
            r_has_free <= 1'b0;
            r_matched  <= 1'b0;
            r_best_len <= '0;
            o_match_route <= '0;
        end else if (i_ctl.step) begin
            r_idx <= w_next_idx;
            if (!w_row_valid) begin
                if (!r_has_free) begin
                    r_has_free <= 1'b1;
                    r_free_idx <= r_idx;
                end
            end else if (w_fam_eq) begin
                if (r_cmd == lpm_pkg::CMD_LOOKUP) begin
                    if (w_cover && (!r_matched || r_row[23:16] > r_best_len)) begin
                        r_matched     <= 1'b1;
                        r_best_len    <= r_row[23:16];
                        o_match_route <= r_row[15:0];
                    end
                end else if (w_exact && !r_matched) begin
                    r_matched <= 1'b1;
                end
            end
        end
    end

    // row read ahead of the scan index, route overwrite on exact match or fill
    always_ff @(posedge i_clk) begin
        r_row <= r_mem[i_ctl.step ? w_next_idx : r_idx];
        if (i_ctl.step && r_cmd == lpm_pkg::CMD_INSERT && w_row_valid && w_fam_eq
            && w_exact && !r_matched) begin
            r_mem[r_idx][15:0] <= r_route;
        end else if (i_ctl.write) begin
            r_mem[r_free_idx] <= {r_fam, w_ins_prefix, r_len, r_route};
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= '0;
        else if (i_ctl.write) r_valid[r_free_idx] <= 1'b1;
    end

    assign o_sts.is_lookup = (r_cmd == lpm_pkg::CMD_LOOKUP);
    assign o_sts.bad_len   = r_fam ? (r_len > lpm_pkg::V6WidthLen)
                                   : (r_len > lpm_pkg::V4WidthLen);
    assign o_sts.last      = (r_idx == IdxW'(TABLE_ENTRIES - 1));
    assign o_sts.matched   = r_matched;
    assign o_sts.has_free  = r_has_free;
endmodule
`default_nettype wire

[rtl/longest_prefix_match_table_core.sv]
// an accepted start steps the controller through check, a scan of every entry and finish;
// a new request is taken only once the previous one is done (a bad insert length skips the
// scan); the scan reads one row of the entry memory per cycle; busy is low in the result cycle
// reset: synchronous active-low i_rst_n empties the table and idles the controller
// the result is strobed for one cycle and cannot be stalled
`default_nettype none
module longest_prefix_match_table_core #(
    parameter int unsigned TABLE_ENTRIES = lpm_pkg::TableEntriesDefault
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         i_command,
    input  wire         i_is_v6,
    input  wire [63:0]  i_address_high,
    input  wire [63:0]  i_address_low,
    input  wire [7:0]   i_prefix_len,
    input  wire [15:0]  i_route_in,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_route_out
);
    lpm_pkg::t_ctl w_ctl;
    lpm_pkg::t_sts w_sts;
    logic [15:0]   w_best;
    logic [1:0]    w_sel;

    lpm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_sts(w_sts),
        .o_ctl(w_ctl), .o_busy(busy), .o_done(o_valid), .o_status_sel(w_sel)
    );

    lpm_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_command(i_command), .i_is_v6(i_is_v6),
        .i_address_high(i_address_high), .i_address_low(i_address_low),
        .i_prefix_len(i_prefix_len), .i_route_in(i_route_in),
        .o_sts(w_sts), .o_match_route(w_best)
    );

    // route only on lookup hit
    assign o_status    = w_sel;
    assign o_route_out = (w_sel == lpm_pkg::ST_OK && w_sts.is_lookup) ? w_best : 16'd0;
endmodule
`default_nettype wire

[rtl/lpm_checker.sv]
`default_nettype none
`include "longest_prefix_match_table_core_defines.svh"
module lpm_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        start,
    input wire        busy,
    input wire        o_valid,
    input wire [1:0]  o_status,
    input wire [15:0] o_route_out
);
    `LPM_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "no busy after start")
    `LPM_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_valid, !busy, "busy during result")
    `LPM_ASSERT_IMPL(a_valid_busy, i_clk, i_rst_n, o_valid, $past(busy), "result without request")
    `LPM_ASSERT_IMPL(a_route_zero, i_clk, i_rst_n, o_valid && o_status != lpm_pkg::ST_OK,
        o_route_out == 16'd0, "route on miss")
endmodule
bind longest_prefix_match_table_core lpm_checker u_lpm_checker (.*);
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// expected route results held in order of request acceptance
class lpm_scoreboard;
    localparam int N = lpm_pkg::TableEntriesDefault;
    bit          ent_valid [N];
    bit          ent_fam   [N];
    bit [127:0]  ent_pfx   [N];
    bit [7:0]    ent_len   [N];
    bit [15:0]   ent_route [N];
    bit [1:0]    exp_status [$];
    bit [15:0]   exp_route  [$];
    int          errors;

    function void clear_table();
        foreach (ent_valid[i]) ent_valid[i] = 1'b0;
    endfunction

    function bit [127:0] len_mask(bit [7:0] len);
        bit [127:0] m;
        m = '0;
        for (int b = 0; b < 128; b++) m[127 - b] = (b < len);
        return m;
    endfunction

    // predict one request and update the table copy
    function void note_request(bit cmd, bit v6, bit [127:0] addr, bit [7:0] len,
                               bit [15:0] route);
        bit [127:0] p;
        int free_slot;
        bit hit;
        bit [7:0] best_len;
        bit [15:0] hit_route;
        bit done;
        free_slot = -1;
        hit = 0;
        best_len = 0;
        hit_route = 0;
        done = 0;
        if (cmd == lpm_pkg::CMD_INSERT) begin
            if (len > (v6 ? lpm_pkg::V6WidthLen : lpm_pkg::V4WidthLen)) begin
                exp_status.push_back(lpm_pkg::ST_BADLEN);
                exp_route.push_back('0);
                return;
            end
            p = addr & len_mask(len);
            for (int i = 0; i < N && !done; i++) begin
                if (!ent_valid[i]) begin
                    if (free_slot < 0) free_slot = i;
                end else if (ent_fam[i] == v6 && ent_len[i] == len && ent_pfx[i] == p) begin
                    ent_route[i] = route;
                    done = 1;
                end
            end
            if (!done && free_slot < 0) begin
                exp_status.push_back(lpm_pkg::ST_FULL);
            end else begin
                if (!done) begin
                    ent_valid[free_slot] = 1;
                    ent_fam[free_slot] = v6;
                    ent_pfx[free_slot] = p;
                    ent_len[free_slot] = len;
                    ent_route[free_slot] = route;
                end
                exp_status.push_back(lpm_pkg::ST_OK);
            end
            exp_route.push_back('0);
        end else begin
            for (int i = 0; i < N; i++) begin
                if (ent_valid[i] && ent_fam[i] == v6 &&
                    (addr & len_mask(ent_len[i])) == ent_pfx[i] &&
                    (!hit || ent_len[i] > best_len)) begin
                    hit = 1;
                    best_len = ent_len[i];
                    hit_route = ent_route[i];
                end
            end
            exp_status.push_back(hit ? lpm_pkg::ST_OK : lpm_pkg::ST_MISS);
            exp_route.push_back(hit_route);
        end
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task check_result(bit [1:0] st, bit [15:0] rt);
        bit [1:0] es;
        bit [15:0] er;
        if (exp_status.size() == 0) begin
            report($sformatf("unexpected result status %0d route %0h", st, rt));
            return;
        end
        es = exp_status.pop_front();
        er = exp_route.pop_front();
        if (st !== es) report($sformatf("status %0d want %0d", st, es));
        if (rt !== er) report($sformatf("route %0h want %0h", rt, er));
    endtask
endclass

module tb_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    wire         busy;
    logic        i_command;
    logic        i_is_v6;
    logic [63:0] i_address_high;
    logic [63:0] i_address_low;
    logic [7:0]  i_prefix_len;
    logic [15:0] i_route_in;
    wire         o_valid;
    wire [1:0]   o_status;
    wire [15:0]  o_route_out;

    lpm_scoreboard routes_sb;
    int          idle_pct;
    int          req_count;
    bit [127:0]  pool [8];

    longest_prefix_match_table_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_is_v6(i_is_v6), .i_address_high(i_address_high),
        .i_address_low(i_address_low), .i_prefix_len(i_prefix_len),
        .i_route_in(i_route_in), .o_valid(o_valid), .o_status(o_status),
        .o_route_out(o_route_out)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // results are checked at the edge that ends their strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) routes_sb.check_result(o_status, o_route_out);
    end

    // send one request, holding start until it is accepted
    task automatic send_request(bit cmd, bit v6, bit [127:0] addr, bit [7:0] len,
                                bit [15:0] route);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_command      <= cmd;
        i_is_v6        <= v6;
        i_address_high <= addr[127:64];
        i_address_low  <= addr[63:0];
        i_prefix_len   <= len;
        i_route_in     <= route;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        routes_sb.note_request(cmd, v6, addr, len, route);
        req_count++;
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        while (routes_sb.exp_status.size() != 0) @(posedge i_clk);
    endtask

    function automatic bit [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // random request mostly aimed at a small pool of prefixes
    task automatic random_request();
        bit [127:0] a;
        bit v6;
        bit [7:0] len;
        v6 = 1'($urandom_range(1));
        a = pool[$urandom_range(7)];
        if ($urandom_range(3) == 0) a = rand128();
        else a ^= rand128() >> $urandom_range(127);
        if (v6) len = ($urandom_range(19) == 0) ? 8'($urandom_range(255))
                                                : 8'($urandom_range(128));
        else len = ($urandom_range(19) == 0) ? 8'($urandom_range(255))
                                             : 8'($urandom_range(32));
        send_request(1'($urandom_range(1)), v6, a, len, 16'($urandom));
    endtask

    initial begin
        routes_sb = new();
        routes_sb.clear_table();
        idle_pct = 0;
        req_count = 0;
        i_rst_n = 0; start = 0; i_command = 0; i_is_v6 = 0;
        i_address_high = 0; i_address_low = 0; i_prefix_len = 0; i_route_in = 0;
        foreach (pool[i]) pool[i] = rand128();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: misses, default routes, extremes, bad lengths, overwrite
        send_request(lpm_pkg::CMD_LOOKUP, 0, '1, 0, '1);
        send_request(lpm_pkg::CMD_INSERT, 0, '1, 0, 16'h0001);
        send_request(lpm_pkg::CMD_INSERT, 1, '0, 0, 16'hffff);
        send_request(lpm_pkg::CMD_INSERT, 0, '1, 32, 16'h0002);
        send_request(lpm_pkg::CMD_INSERT, 1, '1, 128, 16'h0003);
        send_request(lpm_pkg::CMD_INSERT, 0, '1, 33, 16'h0004);
        send_request(lpm_pkg::CMD_INSERT, 1, '1, 129, 16'h0005);
        send_request(lpm_pkg::CMD_INSERT, 1, '1, 255, 16'h0006);
        send_request(lpm_pkg::CMD_INSERT, 1, '1, 64, 16'h0007);
        send_request(lpm_pkg::CMD_INSERT, 1, '1, 65, 16'h0008);
        send_request(lpm_pkg::CMD_LOOKUP, 0, '1, 200, 16'h1234);
        send_request(lpm_pkg::CMD_LOOKUP, 0, {32'hffffffff, 96'h0}, 0, 0);
        send_request(lpm_pkg::CMD_LOOKUP, 0, '0, 0, 0);
        send_request(lpm_pkg::CMD_LOOKUP, 1, '1, 0, 0);
        send_request(lpm_pkg::CMD_LOOKUP, 1, {64'hffffffffffffffff, 64'h0}, 0, 0);
        send_request(lpm_pkg::CMD_LOOKUP, 1, {64'hffffffffffffffff, 64'h8000000000000000}, 0, 0);
        send_request(lpm_pkg::CMD_INSERT, 0, '1, 32, 16'habcd);
        send_request(lpm_pkg::CMD_LOOKUP, 0, {32'hffffffff, 96'h5}, 0, 0);
        send_request(lpm_pkg::CMD_LOOKUP, 1, '0, 0, 0);
        // pause until every expected result has been checked
        wait_drain();

        // fill the table to reach the full case
        for (int i = 0; i < 70; i++)
            send_request(lpm_pkg::CMD_INSERT, i[0], rand128(), 8'(8 + i[4:0]), 16'(i));
        send_request(lpm_pkg::CMD_INSERT, 0, rand128(), 20, 16'hbeef);
        send_request(lpm_pkg::CMD_INSERT, 0, '1, 32, 16'h7777);
        send_request(lpm_pkg::CMD_LOOKUP, 0, '1, 0, 0);

        // random traffic in three idling phases, table emptied by reset only
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 29 : (ph == 1) ? 57 : 0;
            repeat (250) random_request();
        end
        wait_drain();
        repeat (100) @(posedge i_clk);
        $display("covered %0d requests: inserts, lookups, overwrite, full table, bad length",
                 req_count);
        $display("idling phases of 29, 57 and 0 percent on the request side");
        if (routes_sb.errors == 0 && routes_sb.exp_status.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

`default_nettype wire

[sim.f]
+incdir+rtl
rtl/lpm_pkg.sv
rtl/lpm_ctrl.sv
rtl/lpm_datapath.sv
rtl/longest_prefix_match_table_core.sv
rtl/lpm_checker.sv
dv/tb_top.sv
